FILE: hdl/apcr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package apcr_pkg;

    localparam int SMP_W      = 24;
    localparam int NUM_COMBS  = 8;
    localparam int NUM_APS    = 4;
    localparam int COMB_DEPTH = 2048;
    localparam int AP_DEPTH   = 2048;
    localparam int CB_AW      = 14;
    localparam int CL_AW      = 11;
    localparam int AP_AW      = 11;
    localparam int POS_W      = 10;

    // Q1.16 coefficients
    localparam logic [16:0] UNITY    = 17'd65536;
    localparam logic [18:0] FB_SPAN  = 19'd45875;
    localparam logic [16:0] FB_BASE  = 17'd18350;
    localparam logic [18:0] DMP_SPAN = 19'd62259;
    localparam logic [16:0] C_MIN    = 17'd655;
    localparam logic [16:0] C_MAX    = 17'd64881;

    // whole-sample comb delays and allpass regions
    localparam logic [CL_AW-1:0] COMB_DLY [NUM_COMBS] =
        '{11'd1116, 11'd1188, 11'd1277, 11'd1356, 11'd1422, 11'd1491, 11'd1557, 11'd1617};
    localparam logic [AP_AW-1:0] AP_BASE [NUM_APS] = '{11'd0, 11'd556, 11'd997, 11'd1338};
    localparam logic [POS_W-1:0] AP_LEN  [NUM_APS] = '{10'd556, 10'd441, 10'd341, 10'd225};

    typedef enum logic [2:0] {
        REG_ROOM   = 3'd0,
        REG_DAMP   = 3'd1,
        REG_WIDTH  = 3'd2,
        REG_WET    = 3'd3,
        REG_DRY    = 3'd4,
        REG_FREEZE = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [16:0] room;
        logic [16:0] damp;
        logic [16:0] wid;
        logic [16:0] wet;
        logic [16:0] dry;
        logic        freeze;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_FB, ST_DC, ST_DRY, ST_AP,
        ST_CM1, ST_CM2, ST_CM3, ST_CM4, ST_CWR,
        ST_WM, ST_WL, ST_FIN, ST_PUT
    } t_state;

    function automatic logic signed [SMP_W-1:0] sat_smp(input logic signed [31:0] v);
        logic signed [31:0] hi;
        logic signed [31:0] lo;
        hi = 32'sd8388607;
        lo = -32'sd8388608;
        if (v > hi) sat_smp = 24'sh7FFFFF;
        else if (v < lo) sat_smp = 24'sh800000;
        else sat_smp = v[SMP_W-1:0];
    endfunction

    function automatic logic signed [27:0] rnd16(input logic signed [43:0] v);
        logic signed [43:0] t;
        t = v + 44'sd32768;
        rnd16 = t[43:16];
    endfunction

    function automatic logic signed [26:0] rnd17(input logic signed [43:0] v);
        logic signed [43:0] t;
        t = v + 44'sd65536;
        rnd17 = t[43:17];
    endfunction

    function automatic logic [16:0] q16(input logic [16:0] v);
        q16 = (v > UNITY) ? UNITY : v;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/apcr_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module apcr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: hdl/apcr_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
module apcr_cfg
    import apcr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [16:0] i_cfg_data,
    output t_cfg             o_cfg
);
    logic [16:0] r_room, r_damp, r_wid, r_wet, r_dry;
    logic        r_freeze;

    assign o_cfg_ready = 1'b1;

    // take a register write transaction; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_room   <= 17'd32768;
            r_damp   <= 17'd32768;
            r_wid    <= 17'd65536;
            r_wet    <= 17'd21627;
            r_dry    <= 17'd26214;
            r_freeze <= 1'b0;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_ROOM:   r_room   <= i_cfg_data;
                REG_DAMP:   r_damp   <= i_cfg_data;
                REG_WIDTH:  r_wid    <= i_cfg_data;
                REG_WET:    r_wet    <= i_cfg_data;
                REG_DRY:    r_dry    <= i_cfg_data;
                REG_FREEZE: r_freeze <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // clamp gains to unity
    always_comb begin
        o_cfg.room   = q16(r_room);
        o_cfg.damp   = q16(r_damp);
        o_cfg.wid    = q16(r_wid);
        o_cfg.wet    = q16(r_wet);
        o_cfg.dry    = q16(r_dry);
        o_cfg.freeze = r_freeze;
    end
endmodule
`default_nettype wire

FILE: hdl/apcr_core.sv
`timescale 1ns / 1ps
`default_nettype none
module apcr_core
    import apcr_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  t_cfg                         i_cfg,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic signed [SMP_W-1:0] i_sample_in,
    input  wire logic                    i_channel,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic signed [SMP_W-1:0]      o_sample_out
);
    t_state r_state, n_state;

    logic [CB_AW-1:0]        r_clr;
    logic signed [SMP_W-1:0] r_x, r_ap, r_tap, r_z, r_res;
    logic                    r_ch;
    logic [POS_W-1:0]        r_pos [NUM_APS];
    logic [CL_AW-1:0]        r_wp;
    logic [2:0]              r_idx;
    logic signed [SMP_W-1:0] r_damp [NUM_COMBS];
    logic signed [26:0]      r_sum;
    logic signed [43:0]      r_acc, r_prod;
    logic [16:0]             r_fb, r_c;
    logic signed [27:0]      r_dry;

    logic signed [24:0]      mul_a;
    logic signed [18:0]      mul_b;
    logic                    ap_we, cb_we;
    logic [AP_AW-1:0]        ap_waddr, ap_raddr;
    logic [CB_AW-1:0]        cb_waddr, cb_raddr;
    logic [SMP_W-1:0]        ap_wdata, cb_wdata, ap_rdata, cb_rdata;
    logic signed [SMP_W-1:0] ap_y, z_v, back_v;
    logic [1:0]              ap_k, ap_k1;
    logic [2:0]              cb_i1;
    logic signed [27:0]      rnd_p;
    logic [16:0]             c_raw;
    logic [17:0]             wfac;
    logic signed [26:0]      wet1;

    apcr_ram #(.WIDTH(SMP_W), .DEPTH(AP_DEPTH)) u_ap_ram (
        .i_clk(i_clk), .i_we(ap_we), .i_waddr(ap_waddr), .i_wdata(ap_wdata),
        .i_raddr(ap_raddr), .o_rdata(ap_rdata)
    );

    apcr_ram #(.WIDTH(SMP_W), .DEPTH(NUM_COMBS * COMB_DEPTH)) u_cb_ram (
        .i_clk(i_clk), .i_we(cb_we), .i_waddr(cb_waddr), .i_wdata(cb_wdata),
        .i_raddr(cb_raddr), .o_rdata(cb_rdata)
    );

    assign o_in_ready = (r_state == ST_IDLE);
    assign ap_k  = r_idx[1:0];
    assign ap_k1 = r_idx[1:0] + 2'd1;
    assign cb_i1 = r_idx + 3'd1;
    assign rnd_p = rnd16(r_prod);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (r_clr == {CB_AW{1'b1}}) n_state = ST_IDLE;
            ST_IDLE:  if (i_in_valid) n_state = ST_FB;
            ST_FB:    n_state = ST_DC;
            ST_DC:    n_state = ST_DRY;
            ST_DRY:   n_state = ST_AP;
            ST_AP:    if (ap_k == 2'(NUM_APS - 1)) n_state = ST_CM1;
            ST_CM1:   n_state = ST_CM2;
            ST_CM2:   n_state = ST_CM3;
            ST_CM3:   n_state = ST_CM4;
            ST_CM4:   n_state = ST_CWR;
            ST_CWR:   n_state = (r_idx == 3'(NUM_COMBS - 1)) ? ST_WM : ST_CM1;
            ST_WM:    n_state = ST_WL;
            ST_WL:    n_state = ST_FIN;
            ST_FIN:   n_state = ST_PUT;
            ST_PUT:   if (!o_out_valid || i_out_ready) n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    // multiplier operands, memory ports and section arithmetic
    always_comb begin
        mul_a    = '0;
        mul_b    = '0;
        ap_we    = 1'b0;
        ap_waddr = AP_BASE[ap_k] + AP_AW'(r_pos[ap_k]);
        ap_raddr = '0;
        cb_we    = 1'b0;
        cb_waddr = {r_idx, r_wp};
        cb_raddr = '0;
        ap_y     = sat_smp(32'($signed(ap_rdata)) - 32'(r_ap >>> 1));
        ap_wdata = sat_smp(32'(r_ap) + 32'($signed(ap_rdata) >>> 1));
        z_v      = sat_smp(32'(rnd16(r_acc + r_prod)));
        back_v   = i_cfg.freeze ? r_tap : sat_smp(32'(rnd_p));
        cb_wdata = sat_smp(32'(r_ap) + 32'(back_v));
        c_raw    = UNITY - 17'(rnd_p);
        wfac     = r_ch ? (18'(UNITY) - 18'(i_cfg.wid)) : (18'(UNITY) + 18'(i_cfg.wid));
        wet1     = rnd17(r_prod);
        case (r_state)
            ST_CLEAR: begin
                cb_we    = 1'b1;
                cb_waddr = r_clr;
                cb_wdata = '0;
                ap_we    = (r_clr[CB_AW-1:AP_AW] == '0);
                ap_waddr = r_clr[AP_AW-1:0];
                ap_wdata = '0;
            end
            ST_FB: begin
                mul_a = 25'(i_cfg.room);
                mul_b = $signed(FB_SPAN);
            end
            ST_DC: begin
                mul_a = 25'(i_cfg.damp);
                mul_b = $signed(DMP_SPAN);
            end
            ST_DRY: begin
                mul_a    = 25'(r_x);
                mul_b    = $signed({2'b00, i_cfg.dry});
                ap_raddr = AP_BASE[0] + AP_AW'(r_pos[0]);
            end
            ST_AP: begin
                ap_we = 1'b1;
                if (ap_k == 2'(NUM_APS - 1)) begin
                    cb_raddr = {3'd0, r_wp - COMB_DLY[0]};
                end else begin
                    ap_raddr = AP_BASE[ap_k1] + AP_AW'(r_pos[ap_k1]);
                end
            end
            ST_CM1: begin
                mul_a = 25'($signed(cb_rdata));
                mul_b = $signed({2'b00, UNITY - r_c});
            end
            ST_CM2: begin
                mul_a = 25'(r_damp[r_idx]);
                mul_b = $signed({2'b00, r_c});
            end
            ST_CM4: begin
                mul_a = 25'(r_z);
                mul_b = $signed({2'b00, r_fb});
            end
            ST_CWR: begin
                cb_we    = 1'b1;
                cb_raddr = {cb_i1, r_wp - COMB_DLY[cb_i1]};
            end
            ST_WM: begin
                mul_a = 25'(r_sum >>> 3);
                mul_b = $signed({1'b0, wfac});
            end
            ST_WL: begin
                mul_a = 25'(wet1);
                mul_b = $signed({2'b00, i_cfg.wet});
            end
            default: ;
        endcase
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_wp        <= '0;
            r_idx       <= '0;
            o_out_valid <= 1'b0;
            for (int k = 0; k < NUM_APS; k++) r_pos[k] <= '0;
            for (int k = 0; k < NUM_COMBS; k++) r_damp[k] <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr <= r_clr + CB_AW'(1);
            // load a new result, or drop the one taken
            if (r_state == ST_PUT && (!o_out_valid || i_out_ready)) begin
                o_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                ST_DRY: r_idx <= '0;
                ST_AP: begin
                    r_pos[ap_k] <= (r_pos[ap_k] == AP_LEN[ap_k] - POS_W'(1)) ? '0
                                   : r_pos[ap_k] + POS_W'(1);
                    r_idx <= (ap_k == 2'(NUM_APS - 1)) ? 3'd0 : r_idx + 3'd1;
                end
                ST_CM3: r_damp[r_idx] <= z_v;
                ST_CWR: begin
                    r_idx <= cb_i1;
                    if (r_idx == 3'(NUM_COMBS - 1)) r_wp <= r_wp + CL_AW'(1);
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (r_state)
            ST_IDLE: begin
                r_x   <= i_sample_in;
                r_ch  <= i_channel;
                r_sum <= '0;
            end
            ST_DC:  r_fb <= FB_BASE + 17'(rnd_p);
            ST_DRY: begin
                r_c  <= (c_raw < C_MIN) ? C_MIN : ((c_raw > C_MAX) ? C_MAX : c_raw);
                r_ap <= r_x;
            end
            ST_AP: begin
                if (ap_k == 2'd0) r_dry <= rnd_p;
                r_ap <= ap_y;
            end
            ST_CM1: r_tap <= $signed(cb_rdata);
            ST_CM2: r_acc <= r_prod;
            ST_CM3: begin
                r_z   <= z_v;
                r_sum <= r_sum + 27'(z_v);
            end
            ST_FIN: r_res <= sat_smp(32'(rnd_p) + 32'(r_dry));
            ST_PUT: if (!o_out_valid || i_out_ready) o_sample_out <= r_res;
            default: ;
        endcase
    end
endmodule
`default_nettype wire

FILE: hdl/allpass_comb_reverb.sv
// Channel  | Signals                                   | Direction
// input    | i_in_valid/o_in_ready, i_sample_in, i_channel | in
// output   | o_out_valid/i_out_ready, o_sample_out       | out
// config   | i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data | in
//
// A sample passes from acceptance to result through three set-up multiplies, the allpass
// sections in turn, each comb line on the shared multiplier, and the finishing steps; the
// next sample is taken only once the sequencer is back in idle.
// After reset a clearing pass zeroes both delay memories; no sample is taken.
// A result waits in the output register; a new sample is taken while it waits, and the
// sequencer stalls at its last step until the register is free. Config writes never stall.
`timescale 1ns / 1ps
`default_nettype none
module allpass_comb_reverb
    import apcr_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic signed [SMP_W-1:0] i_sample_in,
    input  wire logic                    i_channel,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic signed [SMP_W-1:0]      o_sample_out,
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [2:0]              i_cfg_index,
    input  wire logic [16:0]             i_cfg_data
);
    t_cfg cfg;

    apcr_cfg u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data), .o_cfg(cfg)
    );

    apcr_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(cfg),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_sample_in(i_sample_in), .i_channel(i_channel),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_sample_out(o_sample_out)
    );
endmodule
`default_nettype wire

FILE: hdl/apcr_chk.sv
`timescale 1ns / 1ps
`default_nettype none
module apcr_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [23:0] o_sample_out,
    input wire logic        o_cfg_ready
);
    // reset holds off both data channels
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_ready)
        else $error("channels active after reset");

    // one transaction at a time in the sequencer
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while busy");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_sample_out))
        else $error("stalled result changed");

    // config port never stalls
    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n) o_cfg_ready)
        else $error("config port stalled");
endmodule

bind allpass_comb_reverb apcr_chk u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
    .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_sample_out(o_sample_out),
    .o_cfg_ready(o_cfg_ready)
);
`default_nettype wire

FILE: dv/reverb_checker.sv
`timescale 1ns / 1ps
module reverb_checker
    import apcr_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic signed [SMP_W-1:0] i_sample_in,
    input  logic                    i_channel,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic signed [SMP_W-1:0] i_sample_out,
    input  logic                    i_cfg_valid,
    input  logic                    i_cfg_ready,
    input  logic [2:0]              i_cfg_index,
    input  logic [16:0]             i_cfg_data,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_sample_count
);

    localparam int AP_LEN_I [NUM_APS]    = '{556, 441, 341, 225};
    localparam int AP_BASE_I [NUM_APS]   = '{0, 556, 997, 1338};
    localparam int COMB_DLY_I [NUM_COMBS] = '{1116, 1188, 1277, 1356, 1422, 1491, 1557, 1617};

    // shadow of the network state and settings
    longint comb_line [NUM_COMBS][COMB_DEPTH];
    longint ap_line [AP_DEPTH];
    longint lp_state [NUM_COMBS];
    int     ap_pos [NUM_APS];
    int     comb_wr;
    logic [16:0] room_q, damp_q, width_q, wet_q, dry_q;
    logic        freeze_q;

    logic signed [SMP_W-1:0] expected_samples [$];

    function automatic longint clip(longint v);
        if (v > 64'sd8388607) return 64'sd8388607;
        if (v < -64'sd8388608) return -64'sd8388608;
        return v;
    endfunction

    function automatic longint rshr(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint unity_clip(logic [16:0] v);
        return (v > UNITY) ? 65536 : longint'(v);
    endfunction

    // run one sample through allpass chain and combs, return the mixed output
    task reverb_sample(input logic signed [SMP_W-1:0] smp, input logic ch,
                       output logic signed [SMP_W-1:0] y);
        longint x, ap, b, yy, fb, c, sum, tap, z, back, mean, fac, wet, dry;
        int idx, rp;
        x = longint'(smp);
        ap = x;
        sum = 0;
        fb = 18350 + rshr(unity_clip(room_q) * 45875, 16);
        c = 65536 - rshr(unity_clip(damp_q) * 62259, 16);
        if (c < 655) c = 655;
        if (c > 64881) c = 64881;
        for (int i = 0; i < NUM_APS; i++) begin
            idx = AP_BASE_I[i] + ap_pos[i];
            b = ap_line[idx];
            yy = clip(b - (ap >>> 1));
            ap_line[idx] = clip(ap + (b >>> 1));
            ap_pos[i] = (ap_pos[i] + 1) % AP_LEN_I[i];
            ap = yy;
        end
        // every comb delay is a whole number of samples
        for (int i = 0; i < NUM_COMBS; i++) begin
            rp = (comb_wr + COMB_DEPTH - COMB_DLY_I[i]) % COMB_DEPTH;
            tap = comb_line[i][rp];
            z = clip(rshr(tap * (65536 - c) + lp_state[i] * c, 16));
            back = freeze_q ? tap : clip(rshr(z * fb, 16));
            lp_state[i] = z;
            comb_line[i][comb_wr] = clip(ap + back);
            sum += z;
        end
        comb_wr = (comb_wr + 1) % COMB_DEPTH;
        mean = sum >>> 3;
        fac = ch ? (65536 - unity_clip(width_q)) : (65536 + unity_clip(width_q));
        wet = rshr(mean * fac, 17);
        wet = rshr(wet * unity_clip(wet_q), 16);
        dry = rshr(x * unity_clip(dry_q), 16);
        y = SMP_W'(clip(wet + dry));
    endtask

    assign o_pending = expected_samples.size();

    // predict on input, compare on output, track settings
    always @(posedge i_clk) begin
        logic signed [SMP_W-1:0] y;
        logic signed [SMP_W-1:0] want;
        if (!i_rst_n) begin
            foreach (comb_line[i, j]) comb_line[i][j] = 0;
            foreach (ap_line[i]) ap_line[i] = 0;
            foreach (lp_state[i]) lp_state[i] = 0;
            foreach (ap_pos[i]) ap_pos[i] = 0;
            comb_wr = 0;
            room_q = 17'd32768;
            damp_q = 17'd32768;
            width_q = 17'd65536;
            wet_q = 17'd21627;
            dry_q = 17'd26214;
            freeze_q = 1'b0;
            expected_samples.delete();
            o_fail_count <= 0;
            o_sample_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_ROOM:   room_q = i_cfg_data;
                    REG_DAMP:   damp_q = i_cfg_data;
                    REG_WIDTH:  width_q = i_cfg_data;
                    REG_WET:    wet_q = i_cfg_data;
                    REG_DRY:    dry_q = i_cfg_data;
                    REG_FREEZE: freeze_q = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                o_sample_count <= o_sample_count + 1;
                if (expected_samples.size() == 0) begin
                    $error("sample_out: no result expected, actual %0d", i_sample_out);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_samples.pop_front();
                    if (want !== i_sample_out) begin
                        $error("sample_out: expected %0d, actual %0d", want, i_sample_out);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                reverb_sample(i_sample_in, i_channel, y);
                expected_samples.push_back(y);
            end
        end
    end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
module tb;
    import apcr_pkg::*;

    localparam logic [2:0] REG_SPARE_6 = 3'd6;
    localparam logic [2:0] REG_SPARE_7 = 3'd7;
    localparam int STALL_LIMIT = 100000;
    localparam int SETTLE = 80;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic signed [SMP_W-1:0] sample_in;
    logic                    channel;
    logic                    out_valid;
    logic                    out_ready;
    logic signed [SMP_W-1:0] sample_out;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [2:0]              cfg_index;
    logic [16:0]             cfg_data;
    int                      fail_count;
    int                      pending;
    int                      sample_count;
    int                      quiet_cycles;
    bit                      calm;

    allpass_comb_reverb u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_sample_in  (sample_in),
        .i_channel    (channel),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_sample_out (sample_out),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    reverb_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_sample_in    (sample_in),
        .i_channel      (channel),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_sample_out   (sample_out),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_sample_count (sample_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // end the run if no transaction moves for too long
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // output back-pressure in random bursts
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (calm || $urandom_range(0, 2) != 0) begin
                out_ready = 1'b1;
                repeat ($urandom_range(1, 20)) @(negedge i_clk);
            end else begin
                out_ready = 1'b0;
                repeat ($urandom_range(0, 12)) @(negedge i_clk);
            end
        end
    end

    task send_sample(input logic signed [SMP_W-1:0] smp, input logic ch);
        if (!calm && $urandom_range(0, 4) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        in_valid = 1'b1;
        sample_in = smp;
        channel = ch;
        do @(posedge i_clk); while (!in_ready);
        @(negedge i_clk);
    endtask

    task write_reg(input logic [2:0] idx, input logic [16:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    // hold until every result is back and the sequencer has gone quiet
    task drain();
        in_valid = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic signed [SMP_W-1:0] rand_sample();
        if ($urandom_range(0, 9) < 7) return SMP_W'($urandom);
        return SMP_W'($signed($urandom_range(0, 8191)) - 4096);
    endfunction

    task random_burst(input int n);
        repeat (n) send_sample(rand_sample(), 1'($urandom));
    endtask

    task write_all(input logic [16:0] room, input logic [16:0] damp, input logic [16:0] wid,
                   input logic [16:0] wet, input logic [16:0] dry, input logic [16:0] frz);
        write_reg(REG_ROOM, room);
        write_reg(REG_DAMP, damp);
        write_reg(REG_WIDTH, wid);
        write_reg(REG_WET, wet);
        write_reg(REG_DRY, dry);
        write_reg(REG_FREEZE, frz);
    endtask

    initial begin
        calm = 1'b0;
        in_valid = 1'b0;
        sample_in = '0;
        channel = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_ROOM;
        cfg_data = '0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // extremes of the input at reset settings, both channels
        send_sample(24'sh7FFFFF, 1'b0);
        send_sample(24'sh7FFFFF, 1'b1);
        send_sample(-24'sh800000, 1'b0);
        send_sample(-24'sh800000, 1'b1);
        send_sample(24'sd0, 1'b0);
        send_sample(-24'sd1, 1'b1);
        send_sample(24'sd1, 1'b0);
        send_sample(24'sh555555, 1'b1);
        send_sample(24'shAAAAAA, 1'b0);
        repeat (6) send_sample(24'sh7FFFFF, 1'b0);
        repeat (6) send_sample(-24'sh800000, 1'b1);
        random_burst(420);
        drain();

        // loudest settings: full room, no damping, full wet and dry, narrow image
        write_all(17'd65536, 17'd0, 17'd0, 17'd65536, 17'd65536, 17'd0);
        random_burst(220);
        drain();

        // frozen tail, over-range values clipped to unity, silent mix gains
        write_all(17'd0, 17'h1FFFF, 17'h1FFFF, 17'd0, 17'd0, 17'd1);
        random_burst(40);
        drain();
        write_all(17'd131071, 17'd65536, 17'd65536, 17'h1FFFF, 17'h1FFFF, 17'd3);
        random_burst(200);
        drain();

        // freeze with bit 0 clear, and writes to unused indexes that must be ignored
        write_reg(REG_FREEZE, 17'd2);
        write_reg(REG_SPARE_6, 17'h1FFFF);
        write_reg(REG_SPARE_7, 17'd0);
        write_all(17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536)),
                  17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536)),
                  17'($urandom_range(0, 65536)), 17'd2);
        random_burst(200);
        drain();

        // last stretch with no idling on either side
        calm = 1'b1;
        write_all(17'($urandom), 17'($urandom), 17'($urandom), 17'($urandom),
                  17'($urandom), 17'd0);
        random_burst(250);
        drain();

        $display("Covered %0d samples over six register settings, incl. freeze and clipping.",
                 sample_count);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/apcr_pkg.sv
hdl/apcr_ram.sv
hdl/apcr_cfg.sv
hdl/apcr_core.sv
hdl/allpass_comb_reverb.sv
hdl/apcr_chk.sv
dv/reverb_checker.sv
dv/tb.sv
